// ----- sv/mfek_pkg.sv -----
`timescale 1ns / 1ps
package mfek_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VB = $clog2(MAX_VERTICES);
  localparam int AW = 2 * VB;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int CAP_BITS = 16;
  localparam int RES_BITS = CAP_BITS + 1;
  localparam int FLOW_BITS = 21;
  localparam int CNT_BITS = 6;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;
  localparam logic [CNT_BITS-1:0] VC_RESET = 6'd32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef enum logic [11:0] {
    ST_CLR   = 12'b000000000001,
    ST_IDLE  = 12'b000000000010,
    ST_COPY  = 12'b000000000100,
    ST_BINIT = 12'b000000001000,
    ST_BPOP  = 12'b000000010000,
    ST_BSCAN = 12'b000000100000,
    ST_TRD   = 12'b000001000000,
    ST_TCMP  = 12'b000010000000,
    ST_ARDF  = 12'b000100000000,
    ST_AWRF  = 12'b001000000000,
    ST_AWRR  = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

endpackage

// ----- sv/max_flow_edmonds_karp.sv -----
`timescale 1ns / 1ps
// Edmonds-Karp maximum flow over a 32-vertex capacity matrix. A load beat
// (tuser = 0) writes one capacity when both vertices are below the vertex
// count; a solve beat (tuser = 1) copies the matrix into the residual memory,
// then per augmenting path runs a breadth-first search (one residual read a
// cycle while scanning a dequeued vertex), a min walk (a read and a compare
// per path edge) and an update walk (a read, a forward write and a reverse
// write per path edge); the residual memory has one read and one write port.
// After reset the capacity memory is cleared, during which no beat is taken.
module max_flow_edmonds_karp
  import mfek_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CNT_BITS-1:0]  cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,  // from_vertex, to_vertex, edge_capacity,
                                         // source_vertex, sink_vertex, zero pad
  input  logic                 s_tuser,  // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,  // max_flow, zero pad
  output logic                 m_tuser   // bad_request
);

  state_t state;
  logic [CNT_BITS-1:0] vcount;
  logic [CNT_BITS-1:0] n;
  logic [AW:0] idx;
  logic [VB-1:0] src, dst, u, vd, cur;
  logic [CNT_BITS-1:0] v, head, tail;
  logic pend;
  logic [MAX_VERTICES-1:0] seen;
  logic [VB-1:0] parent [MAX_VERTICES];
  logic [VB-1:0] queue [MAX_VERTICES];
  logic [RES_BITS-1:0] pmin;
  logic [FLOW_BITS-1:0] flow;
  logic bad;
  logic [FLOW_BITS:0] flow_sum;
  logic [VB-1:0] par;

  logic [VB-1:0] in_from, in_to, in_src, in_dst;
  logic [CAP_BITS-1:0] in_cap;
  logic acc;

  logic cap_we;
  logic [AW-1:0] cap_waddr, cap_raddr;
  logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
  logic res_we;
  logic [AW-1:0] res_waddr, res_raddr;
  logic [RES_BITS-1:0] res_wdata, res_rdata;

  assign in_from = s_tdata[4:0];
  assign in_to   = s_tdata[9:5];
  assign in_cap  = s_tdata[25:10];
  assign in_src  = s_tdata[30:26];
  assign in_dst  = s_tdata[35:31];

  assign n = (vcount > CNT_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES) : vcount;
  assign s_tready = (state == ST_IDLE);
  assign acc = s_tvalid && s_tready;
  assign par = parent[cur];
  assign flow_sum = {1'b0, flow} + (FLOW_BITS+1)'(pmin);

  always_comb begin
    cap_we = 1'b0;
    cap_waddr = idx[AW-1:0];
    cap_wdata = '0;
    if (state == ST_CLR) begin
      cap_we = 1'b1;
    end else if (acc && s_tuser == CMD_LOAD &&
                 CNT_BITS'(in_from) < n && CNT_BITS'(in_to) < n) begin
      cap_we = 1'b1;
      cap_waddr = {in_from, in_to};
      cap_wdata = in_cap;
    end
  end
  assign cap_raddr = idx[AW-1:0];

  always_comb begin
    res_we = 1'b0;
    res_waddr = AW'(idx - 1'b1);
    res_wdata = RES_BITS'(cap_rdata);
    res_raddr = {u, v[VB-1:0]};
    unique case (state)
      ST_COPY: res_we = (idx != '0);
      ST_TRD, ST_ARDF: res_raddr = {par, cur};
      ST_AWRF: begin
        res_we = 1'b1;
        res_waddr = {par, cur};
        res_wdata = res_rdata - pmin;
        res_raddr = {cur, par};
      end
      ST_AWRR: begin
        res_we = 1'b1;
        res_waddr = {cur, par};
        res_wdata = res_rdata + pmin;
      end
      default: ;
    endcase
  end

  mfek_ram #(.DW(CAP_BITS), .AW(AW)) u_cap (
    .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
    .raddr(cap_raddr), .rdata(cap_rdata)
  );

  mfek_ram #(.DW(RES_BITS), .AW(AW)) u_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VC_RESET;
    end else if (cfg_we) begin
      vcount <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      idx <= '0;
      m_tvalid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          idx <= idx + 1'b1;
          if (idx[AW-1:0] == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          idx <= '0;
          if (acc && s_tuser == CMD_SOLVE) begin
            src <= in_src;
            dst <= in_dst;
            flow <= '0;
            if (in_src == in_dst || CNT_BITS'(in_src) >= n || CNT_BITS'(in_dst) >= n) begin
              bad <= 1'b1;
              state <= ST_DONE;
            end else begin
              bad <= 1'b0;
              state <= ST_COPY;
            end
          end
        end
        ST_COPY: begin
          idx <= idx + 1'b1;
          if (idx[AW]) begin
            state <= ST_BINIT;
          end
        end
        ST_BINIT: begin
          seen <= MAX_VERTICES'(1) << src;
          parent[src] <= src;
          queue[0] <= src;
          head <= '0;
          tail <= CNT_BITS'(1);
          state <= ST_BPOP;
        end
        ST_BPOP: begin
          if (head == tail) begin
            if (seen[dst]) begin
              cur <= dst;
              pmin <= '1;
              state <= ST_TRD;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            u <= queue[head[VB-1:0]];
            head <= head + 1'b1;
            v <= '0;
            pend <= 1'b0;
            state <= ST_BSCAN;
          end
        end
        ST_BSCAN: begin
          if (v < n) begin
            vd <= v[VB-1:0];
            v <= v + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_BPOP;
            end
          end
          if (pend && !seen[vd] && res_rdata != '0) begin
            seen[vd] <= 1'b1;
            parent[vd] <= u;
            if (tail < CNT_BITS'(MAX_VERTICES)) begin
              queue[tail[VB-1:0]] <= vd;
              tail <= tail + 1'b1;
            end
          end
        end
        ST_TRD: state <= ST_TCMP;
        ST_TCMP: begin
          if (res_rdata < pmin) begin
            pmin <= res_rdata;
          end
          if (par == src) begin
            cur <= dst;
            state <= ST_ARDF;
          end else begin
            cur <= par;
            state <= ST_TRD;
          end
        end
        ST_ARDF: state <= ST_AWRF;
        ST_AWRF: state <= ST_AWRR;
        ST_AWRR: begin
          if (par == src) begin
            flow <= (flow_sum > (FLOW_BITS+1)'(FLOW_MAX)) ? FLOW_MAX
                                                        : flow_sum[FLOW_BITS-1:0];
            state <= ST_BINIT;
          end else begin
            cur <= par;
            state <= ST_ARDF;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, flow};
      m_tuser <= bad;
    end
  end

endmodule

// ----- sv/mfek_ram.sv -----
`timescale 1ns / 1ps
module mfek_ram #(
  parameter int DW = 16,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
